[sv/mimo_fir_channel_filter_unit_assert.svh]
// Assertion macros used by the port-level checker of the MIMO FIR channel filter.
`ifndef MIMO_FIR_CHANNEL_FILTER_UNIT_ASSERT_SVH
`define MIMO_FIR_CHANNEL_FILTER_UNIT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MFCF_ASSERT_SAME(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mfcf same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define MFCF_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mfcf next-cycle check failed");

`endif

[sv/mfcf_pkg.sv]
// Package with types and constants of the MIMO FIR channel filter.
`default_nettype none

package mfcf_pkg;

    // Opcodes carried on the input tuser.
    localparam int OPC_W = 2;
    localparam logic [OPC_W-1:0] OP_LOAD   = 2'd0;
    localparam logic [OPC_W-1:0] OP_SAMPLE = 2'd1;
    localparam logic [OPC_W-1:0] OP_BLOCK  = 2'd2;

    // Data widths.
    localparam int SMP_W  = 16;
    localparam int CPX_W  = 2 * SMP_W;
    localparam int PROD_W = 2 * SMP_W;
    localparam int TERM_W = PROD_W + 1;
    localparam int ACC_W  = 39;
    localparam int ANT_W  = 3;

    // Input tdata layout, lowest bit first.
    localparam int TAP_LSB    = 0;
    localparam int TAP_FLD_W  = 4;
    localparam int RX_LSB     = 4;
    localparam int RX_FLD_W   = 3;
    localparam int TX_LSB     = 7;
    localparam int TX_FLD_W   = 2;
    localparam int LANE_LSB   = 9;
    localparam int IN_TDATA_W = 144;

    // Output tdata: real part, imaginary part, two pad bits.
    localparam int OUT_PAD_W   = 2;
    localparam int OUT_TDATA_W = 2 * ACC_W + OUT_PAD_W;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RUN,
        ST_DRAIN
    } t_state;

endpackage

`default_nettype wire

[sv/mimo_fir_channel_filter_unit.sv]
// Top level of the MIMO FIR channel filter: coefficient and history memories, MAC pipeline.
//
//   channel   | direction | tdata                               | tuser        | tlast
//   ----------+-----------+-------------------------------------+--------------+-----------
//   s (items) | in        | tap, rx, tx, lane0..3 re/im (144 b) | opcode (2 b) | -
//   m (rx)    | out       | re, im (80 b)                       | antenna (3 b)| last rx
//
// A sample runs RX_ANTENNAS*TAPS*TX_ANTENNAS complex multiply-accumulates, one per cycle
// while the output does not stall, on the single shared complex multiplier.
// After reset a clearing pass zeroes the coefficient memory, one entry a cycle, over all
// 2^(clog2(TAPS)+clog2(RX_ANTENNAS)+clog2(TX_ANTENNAS)) entries (32 at the defaults).
// A finished sum meeting a full, stalled output freezes the whole multiply-accumulate pipeline until the transfer.
`default_nettype none

module mimo_fir_channel_filter_unit
    import mfcf_pkg::*;
#(
    parameter int TAPS        = 8,
    parameter int TX_ANTENNAS = 2,
    parameter int RX_ANTENNAS = 2
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_s_tvalid,
    output logic                        o_s_tready,
    // tdata: tap_index, rx_index, tx_index, lane0_re, lane0_im, lane1_re, lane1_im,
    //        lane2_re, lane2_im, lane3_re, lane3_im, zero pad
    input  wire logic [IN_TDATA_W-1:0]  i_s_tdata,
    // tuser: opcode
    input  wire logic [OPC_W-1:0]       i_s_tuser,
    output logic                        o_m_tvalid,
    input  wire logic                   i_m_tready,
    // tdata: out_re, out_im, zero pad
    output logic [OUT_TDATA_W-1:0]      o_m_tdata,
    // tuser: out_antenna
    output logic [ANT_W-1:0]            o_m_tuser,
    output logic                        o_m_tlast
);

    localparam int TW       = (TAPS > 1) ? $clog2(TAPS) : 1;
    localparam int RW       = (RX_ANTENNAS > 1) ? $clog2(RX_ANTENNAS) : 1;
    localparam int XW       = (TX_ANTENNAS > 1) ? $clog2(TX_ANTENNAS) : 1;
    localparam int FW       = $clog2(TAPS + 1);
    localparam int CADDR_W  = TW + RW + XW;
    localparam int CDEPTH   = 1 << CADDR_W;
    localparam int HROW_W   = TX_ANTENNAS * CPX_W;

    localparam logic [TAP_FLD_W:0] TAPS_L = (TAP_FLD_W + 1)'(TAPS);
    localparam logic [RX_FLD_W:0]  RX_L   = (RX_FLD_W + 1)'(RX_ANTENNAS);
    localparam logic [TX_FLD_W:0]  TX_L   = (TX_FLD_W + 1)'(TX_ANTENNAS);
    localparam logic [TW-1:0]      J_MAX  = TW'(TAPS - 1);
    localparam logic [RW-1:0]      R_MAX  = RW'(RX_ANTENNAS - 1);
    localparam logic [XW-1:0]      T_MAX  = XW'(TX_ANTENNAS - 1);
    localparam logic [FW-1:0]      FILL_MAX = FW'(TAPS);

    // Memories: coefficients as {im, re} per (tap, rx, tx); history rows per time slot.
    logic [CPX_W-1:0]   r_coef_mem [CDEPTH];
    logic [HROW_W-1:0]  r_hist_mem [TAPS];
    logic [CPX_W-1:0]   r_coef_q;
    logic [HROW_W-1:0]  r_hist_q;

    // Control state.
    t_state             r_state, n_state;
    logic [CADDR_W-1:0] r_clr_addr, n_clr_addr;
    logic [RW-1:0]      r_r, n_r;
    logic [TW-1:0]      r_j, n_j;
    logic [XW-1:0]      r_t, n_t;
    logic [TW-1:0]      r_wp;
    logic [FW-1:0]      r_fill;
    logic               issue;

    // Pipeline stage 1 (memory read) and stage 2 (products).
    logic               r_s1_vld, r_s1_live, r_s1_first, r_s1_end, r_s1_lastrx;
    logic [XW-1:0]      r_s1_t;
    logic [RW-1:0]      r_s1_r;
    logic               r_s2_vld, r_s2_first, r_s2_end, r_s2_lastrx;
    logic [RW-1:0]      r_s2_r;
    logic signed [PROD_W-1:0] r_p_ac, r_p_bd, r_p_ad, r_p_bc;
    logic signed [ACC_W-1:0]  r_acc_re, r_acc_im;

    // Output register.
    logic                     r_out_vld;
    logic signed [ACC_W-1:0]  r_out_re, r_out_im;
    logic [RW-1:0]            r_out_r;
    logic                     r_out_last;

    logic               in_fire, is_sample, load_ok;
    logic               stall, out_load;
    logic               coef_we;
    logic [CADDR_W-1:0] coef_waddr, coef_raddr;
    logic [CPX_W-1:0]   coef_wdata;
    logic [HROW_W-1:0]  hist_wrow;
    logic [TW-1:0]      wp_next, hist_raddr;
    logic [TW:0]        slot_sum;
    logic [CPX_W-1:0]   hist_lane [TX_ANTENNAS];
    logic [CPX_W-1:0]   smp;
    logic signed [TERM_W-1:0] term_re, term_im;
    logic signed [ACC_W-1:0]  n_acc_re, n_acc_im;

    // Input handshake and decode.
    assign o_s_tready = (r_state == ST_IDLE);
    assign in_fire    = i_s_tvalid && o_s_tready;
    assign is_sample  = i_s_tuser inside {OP_SAMPLE, OP_BLOCK};
    assign load_ok    = (i_s_tuser == OP_LOAD)
                     && ({1'b0, i_s_tdata[TAP_LSB +: TAP_FLD_W]} < TAPS_L)
                     && ({1'b0, i_s_tdata[RX_LSB +: RX_FLD_W]} < RX_L)
                     && ({1'b0, i_s_tdata[TX_LSB +: TX_FLD_W]} < TX_L);

    // Pipeline freezes when a finished sum meets a full, stalled output register.
    assign stall    = r_s2_vld && r_s2_end && r_out_vld && !i_m_tready;
    assign out_load = r_s2_vld && r_s2_end && !stall;

    // Coefficient memory ports: clearing pass or load on write, sequencer on read.
    always_comb begin
        coef_we    = 1'b0;
        coef_waddr = r_clr_addr;
        coef_wdata = '0;
        if (r_state == ST_CLEAR) begin
            coef_we = 1'b1;
        end else if (in_fire && load_ok) begin
            coef_we    = 1'b1;
            coef_waddr = {i_s_tdata[TAP_LSB +: TW], i_s_tdata[RX_LSB +: RW],
                          i_s_tdata[TX_LSB +: XW]};
            coef_wdata = i_s_tdata[LANE_LSB +: CPX_W];
        end
    end
    assign coef_raddr = {r_j, r_r, r_t};

    always_ff @(posedge i_clk) begin
        if (coef_we) begin
            r_coef_mem[coef_waddr] <= coef_wdata;
        end
        if (!stall) begin
            r_coef_q <= r_coef_mem[coef_raddr];
        end
    end

    // History row of the incoming transmit vector, one lane per antenna.
    for (genvar g = 0; g < TX_ANTENNAS; g++) begin : g_lane
        assign hist_wrow[g*CPX_W +: CPX_W] = i_s_tdata[LANE_LSB + g*CPX_W +: CPX_W];
        assign hist_lane[g] = r_hist_q[g*CPX_W +: CPX_W];
    end

    // Circular history: the newest row sits at r_wp, tap j at slot (r_wp - j) mod TAPS.
    assign wp_next  = (r_wp == J_MAX) ? '0 : r_wp + 1'b1;
    assign slot_sum = (r_wp >= r_j) ? ({1'b0, r_wp} - {1'b0, r_j})
                                    : ({1'b0, r_wp} + (TW + 1)'(TAPS) - {1'b0, r_j});
    assign hist_raddr = slot_sum[TW-1:0];

    always_ff @(posedge i_clk) begin
        if (in_fire && is_sample) begin
            r_hist_mem[wp_next] <= hist_wrow;
        end
        if (!stall) begin
            r_hist_q <= r_hist_mem[hist_raddr];
        end
    end

    // History pointer and fill count; a block start restarts the fill count at its own row.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp   <= '0;
            r_fill <= '0;
        end else if (in_fire && is_sample) begin
            r_wp <= wp_next;
            if (i_s_tuser == OP_BLOCK) begin
                r_fill <= FW'(1);
            end else if (r_fill != FILL_MAX) begin
                r_fill <= r_fill + 1'b1;
            end
        end
    end

    // Sequencer: next state and loop counters.
    always_comb begin
        n_state    = r_state;
        n_clr_addr = r_clr_addr;
        n_r        = r_r;
        n_j        = r_j;
        n_t        = r_t;
        issue      = 1'b0;
        case (r_state)
            ST_CLEAR: begin
                n_clr_addr = r_clr_addr + 1'b1;
                if (r_clr_addr == CADDR_W'(CDEPTH - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (in_fire && is_sample) begin
                    n_state = ST_RUN;
                    n_r     = '0;
                    n_j     = '0;
                    n_t     = '0;
                end
            end
            ST_RUN: begin
                if (!stall) begin
                    issue = 1'b1;
                    if (r_t != T_MAX) begin
                        n_t = r_t + 1'b1;
                    end else begin
                        n_t = '0;
                        if (r_j != J_MAX) begin
                            n_j = r_j + 1'b1;
                        end else begin
                            n_j = '0;
                            if (r_r != R_MAX) begin
                                n_r = r_r + 1'b1;
                            end else begin
                                n_state = ST_DRAIN;
                            end
                        end
                    end
                end
            end
            ST_DRAIN: begin
                if (out_load && r_s2_lastrx) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLEAR;
            r_clr_addr <= '0;
            r_r        <= '0;
            r_j        <= '0;
            r_t        <= '0;
        end else begin
            r_state    <= n_state;
            r_clr_addr <= n_clr_addr;
            r_r        <= n_r;
            r_j        <= n_j;
            r_t        <= n_t;
        end
    end

    // Stage 1 tags travel alongside the memory reads.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (!stall) begin
            r_s1_vld <= issue;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!stall) begin
            r_s1_t      <= r_t;
            r_s1_r      <= r_r;
            r_s1_live   <= (FW'(r_j) < r_fill);
            r_s1_first  <= (r_j == '0) && (r_t == '0);
            r_s1_end    <= (r_j == J_MAX) && (r_t == T_MAX);
            r_s1_lastrx <= (r_r == R_MAX);
        end
    end

    // Stage 2: four real products of one complex multiply; taps before the block read zero.
    assign smp = r_s1_live ? hist_lane[r_s1_t] : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld <= 1'b0;
        end else if (!stall) begin
            r_s2_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!stall) begin
            r_p_ac      <= $signed(r_coef_q[SMP_W-1:0]) * $signed(smp[SMP_W-1:0]);
            r_p_bd      <= $signed(r_coef_q[CPX_W-1:SMP_W]) * $signed(smp[CPX_W-1:SMP_W]);
            r_p_ad      <= $signed(r_coef_q[SMP_W-1:0]) * $signed(smp[CPX_W-1:SMP_W]);
            r_p_bc      <= $signed(r_coef_q[CPX_W-1:SMP_W]) * $signed(smp[SMP_W-1:0]);
            r_s2_first  <= r_s1_first;
            r_s2_end    <= r_s1_end;
            r_s2_lastrx <= r_s1_lastrx;
            r_s2_r      <= r_s1_r;
        end
    end

    // Stage 3: combine the products and accumulate over taps and transmit antennas.
    assign term_re  = TERM_W'(r_p_ac) - TERM_W'(r_p_bd);
    assign term_im  = TERM_W'(r_p_ad) + TERM_W'(r_p_bc);
    assign n_acc_re = (r_s2_first ? '0 : r_acc_re) + ACC_W'(term_re);
    assign n_acc_im = (r_s2_first ? '0 : r_acc_im) + ACC_W'(term_im);

    always_ff @(posedge i_clk) begin
        if (r_s2_vld && !stall) begin
            r_acc_re <= n_acc_re;
            r_acc_im <= n_acc_im;
        end
    end

    // Output register: loads a finished sum, clears on a transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (out_load) begin
            r_out_vld <= 1'b1;
        end else if (i_m_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_re   <= n_acc_re;
            r_out_im   <= n_acc_im;
            r_out_r    <= r_s2_r;
            r_out_last <= r_s2_lastrx;
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = {{OUT_PAD_W{1'b0}}, r_out_im, r_out_re};
    assign o_m_tuser  = ANT_W'(r_out_r);
    assign o_m_tlast  = r_out_last;

endmodule

`default_nettype wire

[sv/mfcf_checker.sv]
// Port-level checker of the MIMO FIR channel filter and its bind to the top level.
`default_nettype none

`include "mimo_fir_channel_filter_unit_assert.svh"

module mfcf_port_checker
    import mfcf_pkg::*;
#(
    parameter int RX_ANTENNAS = 2
) (
    input wire logic                   i_clk,
    input wire logic                   i_rst_n,
    input wire logic                   o_s_tready,
    input wire logic                   o_m_tvalid,
    input wire logic                   i_m_tready,
    input wire logic [OUT_TDATA_W-1:0] o_m_tdata,
    input wire logic [ANT_W-1:0]       o_m_tuser,
    input wire logic                   o_m_tlast
);

    localparam logic [ANT_W:0] RX_N   = (ANT_W + 1)'(RX_ANTENNAS);
    localparam logic [ANT_W:0] RX_TOP = (ANT_W + 1)'(RX_ANTENNAS - 1);

    logic [ANT_W:0]             ant_ext;
    logic [OUT_TDATA_W+ANT_W:0] m_bus;

    // Antenna number widened for compares, and the whole output group for stability checks.
    assign ant_ext = {1'b0, o_m_tuser};
    assign m_bus   = {o_m_tlast, o_m_tuser, o_m_tdata};

    // A stalled result holds until its transfer.
    `MFCF_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_m_tvalid && !i_m_tready, o_m_tvalid && $stable(m_bus))

    // Antenna numbers stay within the configured receive antennas.
    `MFCF_ASSERT_SAME(a_ant_range, i_clk, i_rst_n, o_m_tvalid, ant_ext < RX_N)

    // The last flag marks exactly the highest receive antenna.
    `MFCF_ASSERT_SAME(a_last_ant, i_clk, i_rst_n, o_m_tvalid, o_m_tlast == (ant_ext == RX_TOP))

    // A new item is taken only once every result of the previous sample is out or last.
    `MFCF_ASSERT_SAME(a_ready_after_last, i_clk, i_rst_n, o_m_tvalid && o_s_tready, o_m_tlast)

endmodule

bind mimo_fir_channel_filter_unit mfcf_port_checker #(
    .RX_ANTENNAS (RX_ANTENNAS)
) u_mfcf_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser),
    .o_m_tlast  (o_m_tlast)
);

`default_nettype wire

[verif/mfcf_checker.sv]
// Checker for the MIMO FIR channel filter: predicts each receive sample and compares the transfers.
`timescale 1ns / 1ps

module mfcf_checker
    import mfcf_pkg::*;
#(
    parameter int TAPS        = 8,
    parameter int TX_ANTENNAS = 2,
    parameter int RX_ANTENNAS = 2
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_s_tvalid,
    input  wire logic                   i_s_tready,
    // tdata: tap_index, rx_index, tx_index, lane0_re, lane0_im, ... lane3_im, zero pad
    input  wire logic [IN_TDATA_W-1:0]  i_s_tdata,
    // tuser: opcode
    input  wire logic [OPC_W-1:0]       i_s_tuser,
    input  wire logic                   i_m_tvalid,
    input  wire logic                   i_m_tready,
    // tdata: out_re, out_im, zero pad
    input  wire logic [OUT_TDATA_W-1:0] i_m_tdata,
    // tuser: out_antenna
    input  wire logic [ANT_W-1:0]       i_m_tuser,
    input  wire logic                   i_m_tlast,
    output int                          o_fail_count,
    output int                          o_pending,
    output int                          o_checked
);

    // Complex value laid out as on the bus: real part in the low half.
    typedef struct packed {
        logic [SMP_W-1:0] im;
        logic [SMP_W-1:0] re;
    } cplx_t;

    typedef struct packed {
        logic [ANT_W-1:0] antenna;
        logic [ACC_W-1:0] re;
        logic [ACC_W-1:0] im;
        logic             last;
    } rx_sample_t;

    cplx_t      tap_matrix [TAPS][RX_ANTENNAS][TX_ANTENNAS];
    cplx_t      tx_history [TAPS][TX_ANTENNAS];
    rx_sample_t rx_sample_q [$];

    // Report one failure and count it.
    task automatic report_mismatch(input string field, input logic [63:0] want,
                                   input logic [63:0] got);
        $display("%0t: mismatch on %s, expected %0h, actual %0h", $time, field, want, got);
        o_fail_count++;
    endtask

    // Apply one accepted item to the filter state and queue the receive samples it yields.
    task automatic filter_item(input logic [OPC_W-1:0] op, input logic [IN_TDATA_W-1:0] data);
        logic [TAP_FLD_W-1:0] tap;
        logic [RX_FLD_W-1:0]  rx;
        logic [TX_FLD_W-1:0]  tx;
        longint               a, b, c, d, acc_re, acc_im;
        rx_sample_t           res;
        tap = data[TAP_LSB +: TAP_FLD_W];
        rx  = data[RX_LSB +: RX_FLD_W];
        tx  = data[TX_LSB +: TX_FLD_W];
        case (op)
            OP_LOAD: begin
                // Writes outside the configured matrix are dropped.
                if (tap < TAPS && rx < RX_ANTENNAS && tx < TX_ANTENNAS)
                    tap_matrix[tap][rx][tx] = data[LANE_LSB +: CPX_W];
            end
            OP_SAMPLE, OP_BLOCK: begin
                // A block start forgets everything sent before it.
                if (op == OP_BLOCK) begin
                    for (int j = 0; j < TAPS; j++)
                        for (int t = 0; t < TX_ANTENNAS; t++)
                            tx_history[j][t] = '0;
                end
                for (int j = TAPS - 1; j > 0; j--)
                    for (int t = 0; t < TX_ANTENNAS; t++)
                        tx_history[j][t] = tx_history[j-1][t];
                for (int t = 0; t < TX_ANTENNAS; t++)
                    tx_history[0][t] = data[LANE_LSB + CPX_W*t +: CPX_W];
                // Exact complex product-sum per receive antenna.
                for (int r = 0; r < RX_ANTENNAS; r++) begin
                    acc_re = 0;
                    acc_im = 0;
                    for (int j = 0; j < TAPS; j++) begin
                        for (int t = 0; t < TX_ANTENNAS; t++) begin
                            a = $signed(tap_matrix[j][r][t].re);
                            b = $signed(tap_matrix[j][r][t].im);
                            c = $signed(tx_history[j][t].re);
                            d = $signed(tx_history[j][t].im);
                            acc_re += a * c - b * d;
                            acc_im += a * d + b * c;
                        end
                    end
                    res.antenna = r[ANT_W-1:0];
                    res.re      = acc_re[ACC_W-1:0];
                    res.im      = acc_im[ACC_W-1:0];
                    res.last    = (r == RX_ANTENNAS - 1);
                    rx_sample_q.push_back(res);
                end
            end
            default: begin
                // Reserved opcode: the block ignores the item.
            end
        endcase
    endtask

    // Compare outgoing transfers first, then fold in the incoming item of the same edge.
    always @(posedge i_clk) begin
        rx_sample_t want;
        if (!i_rst_n) begin
            for (int j = 0; j < TAPS; j++) begin
                for (int t = 0; t < TX_ANTENNAS; t++) begin
                    tx_history[j][t] = '0;
                    for (int r = 0; r < RX_ANTENNAS; r++)
                        tap_matrix[j][r][t] = '0;
                end
            end
            rx_sample_q.delete();
            o_fail_count = 0;
            o_checked    = 0;
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                o_checked++;
                if (rx_sample_q.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual antenna %0d",
                             $time, i_m_tuser);
                    o_fail_count++;
                end else begin
                    want = rx_sample_q.pop_front();
                    if (i_m_tuser !== want.antenna)
                        report_mismatch("out_antenna", 64'(want.antenna), 64'(i_m_tuser));
                    if (i_m_tdata[0 +: ACC_W] !== want.re)
                        report_mismatch("out_re", 64'(want.re), 64'(i_m_tdata[0 +: ACC_W]));
                    if (i_m_tdata[ACC_W +: ACC_W] !== want.im)
                        report_mismatch("out_im", 64'(want.im),
                                        64'(i_m_tdata[ACC_W +: ACC_W]));
                    if (i_m_tlast !== want.last)
                        report_mismatch("out_last", 64'(want.last), 64'(i_m_tlast));
                end
            end
            if (i_s_tvalid && i_s_tready)
                filter_item(i_s_tuser, i_s_tdata);
        end
        o_pending = rx_sample_q.size();
    end

endmodule

[verif/tb_mimo_fir_channel_filter_unit.sv]
// Testbench top for the MIMO FIR channel filter: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_mimo_fir_channel_filter_unit;
    import mfcf_pkg::*;

    localparam int NUM_TAPS     = 8;
    localparam int NUM_TX       = 2;
    localparam int NUM_RX       = 2;
    localparam int LANES_W      = 4 * CPX_W;
    localparam int RANDOM_ITEMS = 300;
    localparam int SAMPLE_CYCLES = NUM_RX * NUM_TAPS * NUM_TX + 3;

    // The reserved opcode, which the block must ignore.
    localparam logic [OPC_W-1:0] OP_IGNORED = 2'd3;

    logic                   i_clk      = 1'b0;
    logic                   i_rst_n    = 1'b0;
    logic                   i_s_tvalid = 1'b0;
    logic                   o_s_tready;
    logic [IN_TDATA_W-1:0]  i_s_tdata  = '0;
    logic [OPC_W-1:0]       i_s_tuser  = OP_LOAD;
    logic                   o_m_tvalid;
    logic                   i_m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] o_m_tdata;
    logic [ANT_W-1:0]       o_m_tuser;
    logic                   o_m_tlast;

    int chk_fail_count;
    int chk_pending;
    int chk_checked;

    // Both sides leave out their random stalls while this is set.
    bit calm_phase = 1'b0;

    int n_loads, n_loads_outside, n_samples, n_blocks, n_ignored;

    always #6 i_clk = ~i_clk;

    mimo_fir_channel_filter_unit #(
        .TAPS        (NUM_TAPS),
        .TX_ANTENNAS (NUM_TX),
        .RX_ANTENNAS (NUM_RX)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

    mfcf_checker #(
        .TAPS        (NUM_TAPS),
        .TX_ANTENNAS (NUM_TX),
        .RX_ANTENNAS (NUM_RX)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (i_s_tvalid),
        .i_s_tready   (o_s_tready),
        .i_s_tdata    (i_s_tdata),
        .i_s_tuser    (i_s_tuser),
        .i_m_tvalid   (o_m_tvalid),
        .i_m_tready   (i_m_tready),
        .i_m_tdata    (o_m_tdata),
        .i_m_tuser    (o_m_tuser),
        .i_m_tlast    (o_m_tlast),
        .o_fail_count (chk_fail_count),
        .o_pending    (chk_pending),
        .o_checked    (chk_checked)
    );

    // Sample values leaning toward the two extremes, so sums reach their largest magnitudes.
    function automatic logic [SMP_W-1:0] pick_value();
        case ($urandom_range(0, 7))
            0:       return 16'h8000;
            1:       return 16'h7fff;
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic logic [LANES_W-1:0] random_lanes();
        logic [LANES_W-1:0] lanes;
        for (int k = 0; k < 8; k++)
            lanes[SMP_W*k +: SMP_W] = pick_value();
        return lanes;
    endfunction

    // Present one item at the falling edge and hold it until the transfer.
    task automatic send_item(input logic [OPC_W-1:0] op, input logic [3:0] tap,
                             input logic [2:0] rx, input logic [1:0] tx,
                             input logic [LANES_W-1:0] lanes);
        logic [IN_TDATA_W-1:0] data;
        data = '0;
        data[TAP_LSB +: TAP_FLD_W] = tap;
        data[RX_LSB +: RX_FLD_W]   = rx;
        data[TX_LSB +: TX_FLD_W]   = tx;
        data[LANE_LSB +: LANES_W]  = lanes;
        @(negedge i_clk);
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= op;
        i_s_tdata  <= data;
        do @(posedge i_clk); while (!o_s_tready);
        case (op)
            OP_LOAD: begin
                n_loads++;
                if (tap >= NUM_TAPS || rx >= NUM_RX || tx >= NUM_TX)
                    n_loads_outside++;
            end
            OP_SAMPLE: n_samples++;
            OP_BLOCK:  n_blocks++;
            default:   n_ignored++;
        endcase
    endtask

    // Hold the input side idle until every predicted result has been transferred.
    task automatic wait_for_results();
        do begin
            @(negedge i_clk);
            i_s_tvalid <= 1'b0;
        end while (chk_pending != 0);
    endtask

    // Receiver: random stall bursts outside the calm phases.
    initial begin
        int stall_left;
        stall_left = 0;
        forever begin
            @(negedge i_clk);
            if (stall_left > 0) begin
                i_m_tready <= 1'b0;
                stall_left--;
            end else if (!calm_phase && $urandom_range(0, 4) == 0) begin
                i_m_tready <= 1'b0;
                stall_left = $urandom_range(0, 5);
            end else begin
                i_m_tready <= 1'b1;
            end
        end
    end

    // Watchdog far above the slowest legal run.
    initial begin
        #2_000_000;
        $display("tb_mimo_fir_channel_filter_unit: FAIL");
        $finish;
    end

    initial begin
        logic [LANES_W-1:0] noise;
        int                 random_done;
        int                 pick;
        int                 total_fails;
        bit                 paused;
        random_done = 0;
        paused      = 1'b0;

        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // A sample against the untouched all-zero matrix.
        send_item(OP_SAMPLE, 4'd0, 3'd0, 2'd0, {8{16'h8000}});

        // Extreme and near-zero coefficients, mostly in the corners of the matrix; other lanes carry noise.
        noise = random_lanes();
        send_item(OP_LOAD, 4'd0, 3'd0, 2'd0, {noise[LANES_W-1:32], 16'h8000, 16'h7fff});
        noise = random_lanes();
        send_item(OP_LOAD, 4'd0, 3'd1, 2'd1, {noise[LANES_W-1:32], 16'h8000, 16'h8000});
        noise = random_lanes();
        send_item(OP_LOAD, 4'(NUM_TAPS - 1), 3'(NUM_RX - 1), 2'(NUM_TX - 1),
                  {noise[LANES_W-1:32], 16'h7fff, 16'h8000});
        noise = random_lanes();
        send_item(OP_LOAD, 4'd3, 3'd0, 2'd1, {noise[LANES_W-1:32], 16'h7fff, 16'h7fff});
        noise = random_lanes();
        send_item(OP_LOAD, 4'd0, 3'd1, 2'd0, {noise[LANES_W-1:32], 16'hffff, 16'h0001});

        // Loads outside the matrix must leave it untouched.
        send_item(OP_LOAD, 4'd15, 3'd0, 2'd0, random_lanes());
        send_item(OP_LOAD, 4'd0, 3'd7, 2'd0, random_lanes());
        send_item(OP_LOAD, 4'd0, 3'd0, 2'd3, random_lanes());
        send_item(OP_IGNORED, 4'd0, 3'd0, 2'd0, random_lanes());

        // Block start, then a full history of alternating extremes; unused lanes get noise.
        noise = random_lanes();
        send_item(OP_BLOCK, 4'd15, 3'd7, 2'd3,
                  {noise[LANES_W-1:64], 16'h8000, 16'h7fff, 16'h8000, 16'h8000});
        for (int i = 0; i < NUM_TAPS; i++) begin
            noise = random_lanes();
            send_item(OP_SAMPLE, 4'($urandom_range(0, 15)), 3'($urandom_range(0, 7)),
                      2'($urandom_range(0, 3)),
                      {noise[LANES_W-1:64], (i % 2 == 0) ? {4{16'h8000}} : {4{16'h7fff}}});
        end
        send_item(OP_BLOCK, 4'd0, 3'd0, 2'd0, {8{16'h7fff}});
        send_item(OP_SAMPLE, 4'd0, 3'd0, 2'd0, '0);

        // Random traffic: mostly samples and in-range loads, some noise items.
        while (random_done < RANDOM_ITEMS) begin
            if (random_done >= RANDOM_ITEMS - 60)
                calm_phase = 1'b1;
            else if (random_done % 40 == 0)
                calm_phase = ($urandom_range(0, 2) == 0);

            if (random_done == RANDOM_ITEMS / 2 && !paused) begin
                paused = 1'b1;
                wait_for_results();
            end

            if (!calm_phase && $urandom_range(0, 3) == 0) begin
                repeat ($urandom_range(1, 6)) begin
                    @(negedge i_clk);
                    i_s_tvalid <= 1'b0;
                end
            end

            pick = $urandom_range(0, 99);
            if (pick < 5) begin
                send_item(OP_BLOCK, 4'($urandom_range(0, 15)), 3'($urandom_range(0, 7)),
                          2'($urandom_range(0, 3)), random_lanes());
                random_done++;
            end else if (pick < 65) begin
                send_item(OP_SAMPLE, 4'($urandom_range(0, 15)), 3'($urandom_range(0, 7)),
                          2'($urandom_range(0, 3)), random_lanes());
                random_done++;
            end else if (pick < 87) begin
                send_item(OP_LOAD, 4'($urandom_range(0, NUM_TAPS - 1)),
                          3'($urandom_range(0, NUM_RX - 1)),
                          2'($urandom_range(0, NUM_TX - 1)),
                          random_lanes());
                random_done++;
            end else if (pick < 96) begin
                send_item(OP_LOAD, 4'($urandom_range(0, 15)), 3'($urandom_range(0, 7)),
                          2'($urandom_range(0, 3)), random_lanes());
                random_done++;
            end else begin
                send_item(OP_IGNORED, 4'($urandom_range(0, 15)), 3'($urandom_range(0, 7)),
                          2'($urandom_range(0, 3)), random_lanes());
            end
        end

        // Drain, then give a trailing load time to settle.
        wait_for_results();
        repeat (4 * SAMPLE_CYCLES) @(negedge i_clk);

        total_fails = chk_fail_count;
        if (chk_pending != 0) begin
            $display("%0t: %0d expected results never arrived", $time, chk_pending);
            total_fails++;
        end

        $display("Covered %0d coefficient loads (%0d outside the matrix), %0d samples,",
                 n_loads, n_loads_outside, n_samples);
        $display("%0d block starts and %0d reserved items; %0d receive samples compared.",
                 n_blocks, n_ignored, chk_checked);
        if (total_fails == 0) begin
            $display("tb_mimo_fir_channel_filter_unit: PASS");
        end else begin
            $display("tb_mimo_fir_channel_filter_unit: FAIL");
        end
        $finish;
    end

endmodule
